[rtl/swcm_pkg.sv]
// Shared constants, types and helpers for the swirl coordinate map.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swcm_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int CORDIC_STEPS = 16;

    // Field widths fixed by the interface.
    localparam int DIM_W  = 12;
    localparam int D_W    = DIM_W + 1;
    localparam int RSQ_W  = 2 * DIM_W;
    localparam int SQ_FRAC = 16;
    localparam int N_W    = RSQ_W + SQ_FRAC;
    localparam int ROOT_W = N_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int R_FRAC = SQ_FRAC / 2;
    localparam int Q_W    = 16;
    localparam int F_W    = Q_W + 1;
    localparam int TW_W   = 24;
    localparam int TH_W   = TW_W + F_W;
    localparam int ANG_W  = 32;
    localparam int XY_W   = 32;
    localparam int WORK_SHIFT = 16;
    localparam int GAIN_W = 17;
    localparam int PROD_W = XY_W + GAIN_W;
    localparam int GAIN_SH = 24;
    localparam int OUT_W  = 22;
    localparam int OUT_FRAC = 8;

    localparam logic [GAIN_W-1:0] GAIN_Q16 = 17'd39797;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [ANG_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TWIST    = 2'd3;

    // Queue between the classifying front and the arithmetic back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // One classified coordinate as it travels from front to back.
    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic [RSQ_W-1:0]      rsq;
        logic                  in_rad;
    } swcm_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (32'(v) >= MAX_DIM) ? DIM_W'(MAX_DIM - 1) : v;
    endfunction

endpackage

`default_nettype wire

[rtl/swcm_front.sv]
// Front end of the swirl map: takes destination coordinates, forms the
// offset from the center and decides whether the point lies inside the radius.
// Depends on swcm_pkg.
`default_nettype none

module swcm_front
    import swcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [DIM_W-1:0] dest_x,
    input  logic [DIM_W-1:0] dest_y,
    input  logic [DIM_W-1:0] ctr_x,
    input  logic [DIM_W-1:0] ctr_y,
    input  logic [DIM_W-1:0] radius,
    output logic             out_valid,
    input  logic             out_ready,
    output swcm_item_t       out_item
);

    logic                    en;
    logic                    a_v_reg;
    logic signed [D_W-1:0]   a_dx_reg;
    logic signed [D_W-1:0]   a_dy_reg;
    logic [RSQ_W-1:0]        rad_sq_reg;
    logic                    b_v_reg;
    swcm_item_t              b_item_reg;
    swcm_item_t              b_item_next;
    logic signed [2*D_W-1:0] sqx;
    logic signed [2*D_W-1:0] sqy;
    logic [2*D_W-1:0]        rsq_full;

    assign en       = !b_v_reg || out_ready;
    assign in_ready = en;

    assign sqx      = a_dx_reg * a_dx_reg;
    assign sqy      = a_dy_reg * a_dy_reg;
    assign rsq_full = $unsigned(sqx) + $unsigned(sqy);

    always_comb
    begin
        b_item_next.dx     = a_dx_reg;
        b_item_next.dy     = a_dy_reg;
        b_item_next.rsq    = RSQ_W'(rsq_full);
        b_item_next.in_rad = rsq_full < (2*D_W)'(rad_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_sq_reg <= radius * radius;
        if (en)
        begin
            a_dx_reg   <= $signed({1'b0, clamp_dim(dest_x)}) - $signed({1'b0, ctr_x});
            a_dy_reg   <= $signed({1'b0, clamp_dim(dest_y)}) - $signed({1'b0, ctr_y});
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_v_reg;
    assign out_item  = b_item_reg;

endmodule

`default_nettype wire

[rtl/swcm_queue.sv]
// Short first-in first-out queue between the front and back of the swirl map.
// Depends on swcm_pkg for the item type and depth.
`default_nettype none

module swcm_queue
    import swcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  swcm_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output swcm_item_t out_item
);

    swcm_item_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              wr_en;
    logic              rd_en;

    assign in_ready  = count_reg != (QPTR_W+1)'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

[rtl/swcm_back.sv]
// Back end of the swirl map: square root, division, twist product, CORDIC
// rotation and gain correction, one stage per step, with an output register.
// Depends on swcm_pkg.
`default_nettype none

module swcm_back
    import swcm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  swcm_item_t             in_item,
    input  logic [DIM_W-1:0]       radius,
    input  logic signed [TW_W-1:0] twist,
    input  logic [DIM_W-1:0]       ctr_x,
    input  logic [DIM_W-1:0]       ctr_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       src_x,
    output logic [OUT_W-1:0]       src_y,
    output logic                   inside_res
);

    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic                  in_rad;
        logic [N_W-1:0]        n;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } sq_t;

    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic                  in_rad;
        logic [DIM_W-1:0]      rem;
        logic [Q_W-1:0]        dlo;
        logic [Q_W-1:0]        q;
    } dv_t;

    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic                  in_rad;
        logic [ANG_W-1:0]      theta;
    } mu_t;

    typedef struct packed {
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic                   in_rad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANG_W-1:0]       a;
    } co_t;

    typedef struct packed {
        logic signed [D_W-1:0]    dx;
        logic signed [D_W-1:0]    dy;
        logic                     in_rad;
        logic signed [PROD_W-1:0] gx;
        logic signed [PROD_W-1:0] gy;
    } gn_t;

    localparam logic signed [ANG_W-1:0]  QUARTER     = 32'sh4000_0000;
    localparam logic signed [ANG_W-1:0]  NEG_QUARTER = 32'shC000_0000;
    localparam logic signed [PROD_W-1:0] GAIN_ROUND  = PROD_W'(1) << (GAIN_SH - 1);

    function automatic sq_t sq_step(input sq_t p);
        sq_t              r;
        logic [REM_W+1:0] rsh;
        logic [REM_W+1:0] trial;
        r     = p;
        rsh   = {p.rem, p.n[N_W-1 -: 2]};
        trial = {2'b00, p.root, 2'b01};
        r.n   = {p.n[N_W-3:0], 2'b00};
        if (rsh >= trial)
        begin
            r.rem  = REM_W'(rsh - trial);
            r.root = {p.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(rsh);
            r.root = {p.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_t dv_step(input dv_t p, input logic [DIM_W-1:0] rad);
        dv_t            r;
        logic [DIM_W:0] rs;
        r     = p;
        rs    = {p.rem, p.dlo[Q_W-1]};
        r.dlo = {p.dlo[Q_W-2:0], 1'b0};
        if (rs >= {1'b0, rad})
        begin
            r.rem = DIM_W'(rs - {1'b0, rad});
            r.q   = {p.q[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = DIM_W'(rs);
            r.q   = {p.q[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic co_t co_step(input co_t p, input int i);
        co_t                    r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        r  = p;
        xs = p.x >>> i;
        ys = p.y >>> i;
        if (!p.a[ANG_W-1])
        begin
            r.x = p.x - ys;
            r.y = p.y + xs;
            r.a = p.a - ATAN_TURN32[i];
        end
        else
        begin
            r.x = p.x + ys;
            r.y = p.y - xs;
            r.a = p.a + ATAN_TURN32[i];
        end
        return r;
    endfunction

    logic en;

    sq_t  sq_reg   [ROOT_W+1];
    sq_t  sq_next  [ROOT_W+1];
    logic sq_v_reg [ROOT_W+1];
    dv_t  dv_reg   [Q_W+1];
    dv_t  dv_next  [Q_W+1];
    logic dv_v_reg [Q_W+1];
    mu_t  mu_reg;
    mu_t  mu_next;
    logic mu_v_reg;
    co_t  co_reg   [CORDIC_STEPS+1];
    co_t  co_next  [CORDIC_STEPS+1];
    logic co_v_reg [CORDIC_STEPS+1];
    gn_t  gn_reg;
    gn_t  gn_next;
    logic gn_v_reg;
    logic out_v_reg;
    logic [OUT_W-1:0] src_x_reg;
    logic [OUT_W-1:0] src_y_reg;
    logic             inside_reg;
    logic [OUT_W-1:0] src_x_next;
    logic [OUT_W-1:0] src_y_next;

    logic [F_W-1:0]           f_val;
    logic signed [TH_W-1:0]   theta_full;
    logic [ANG_W-1:0]         a0;
    logic signed [XY_W-1:0]   x0;
    logic signed [XY_W-1:0]   y0;
    logic signed [PROD_W-1:0] rx;
    logic signed [PROD_W-1:0] ry;
    logic signed [D_W-1:0]    px;
    logic signed [D_W-1:0]    py;

    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        sq_next[0].dx     = in_item.dx;
        sq_next[0].dy     = in_item.dy;
        sq_next[0].in_rad = in_item.in_rad;
        sq_next[0].n      = {in_item.rsq, SQ_FRAC'(0)};
        sq_next[0].rem    = '0;
        sq_next[0].root   = '0;
        for (int k = 1; k <= ROOT_W; k++)
            sq_next[k] = sq_step(sq_reg[k-1]);

        dv_next[0].dx     = sq_reg[ROOT_W].dx;
        dv_next[0].dy     = sq_reg[ROOT_W].dy;
        dv_next[0].in_rad = sq_reg[ROOT_W].in_rad;
        dv_next[0].rem    = sq_reg[ROOT_W].root[ROOT_W-1:R_FRAC];
        dv_next[0].dlo    = {sq_reg[ROOT_W].root[R_FRAC-1:0], (Q_W-R_FRAC)'(0)};
        dv_next[0].q      = '0;
        for (int k = 1; k <= Q_W; k++)
            dv_next[k] = dv_step(dv_reg[k-1], radius);

        // Twist falls off linearly from the center: f = 1 - r/radius.
        f_val      = F_W'(1 << Q_W) - F_W'(dv_reg[Q_W].q);
        theta_full = twist * $signed({1'b0, f_val});
        mu_next.dx     = dv_reg[Q_W].dx;
        mu_next.dy     = dv_reg[Q_W].dy;
        mu_next.in_rad = dv_reg[Q_W].in_rad;
        mu_next.theta  = theta_full[ANG_W-1:0];

        // Negative angle; fold into the CORDIC range by a half turn.
        a0 = ANG_W'(0) - mu_reg.theta;
        x0 = XY_W'(mu_reg.dx) <<< WORK_SHIFT;
        y0 = XY_W'(mu_reg.dy) <<< WORK_SHIFT;
        co_next[0].dx     = mu_reg.dx;
        co_next[0].dy     = mu_reg.dy;
        co_next[0].in_rad = mu_reg.in_rad;
        if (($signed(a0) > QUARTER) || ($signed(a0) < NEG_QUARTER))
        begin
            co_next[0].x = -x0;
            co_next[0].y = -y0;
            co_next[0].a = {~a0[ANG_W-1], a0[ANG_W-2:0]};
        end
        else
        begin
            co_next[0].x = x0;
            co_next[0].y = y0;
            co_next[0].a = a0;
        end
        for (int k = 1; k <= CORDIC_STEPS; k++)
            co_next[k] = co_step(co_reg[k-1], k - 1);

        gn_next.dx     = co_reg[CORDIC_STEPS].dx;
        gn_next.dy     = co_reg[CORDIC_STEPS].dy;
        gn_next.in_rad = co_reg[CORDIC_STEPS].in_rad;
        gn_next.gx     = co_reg[CORDIC_STEPS].x * $signed({1'b0, GAIN_Q16});
        gn_next.gy     = co_reg[CORDIC_STEPS].y * $signed({1'b0, GAIN_Q16});

        rx = gn_reg.gx + GAIN_ROUND;
        ry = gn_reg.gy + GAIN_ROUND;
        px = gn_reg.dx + $signed({1'b0, ctr_x});
        py = gn_reg.dy + $signed({1'b0, ctr_y});
        if (gn_reg.in_rad)
        begin
            src_x_next = rx[GAIN_SH +: OUT_W] + OUT_W'({ctr_x, OUT_FRAC'(0)});
            src_y_next = ry[GAIN_SH +: OUT_W] + OUT_W'({ctr_y, OUT_FRAC'(0)});
        end
        else
        begin
            src_x_next = OUT_W'({px[DIM_W-1:0], OUT_FRAC'(0)});
            src_y_next = OUT_W'({py[DIM_W-1:0], OUT_FRAC'(0)});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= Q_W; k++)
                dv_v_reg[k] <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++)
                co_v_reg[k] <= 1'b0;
            mu_v_reg  <= 1'b0;
            gn_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= in_valid;
            for (int k = 1; k <= ROOT_W; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
            for (int k = 1; k <= Q_W; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
            mu_v_reg    <= dv_v_reg[Q_W];
            co_v_reg[0] <= mu_v_reg;
            for (int k = 1; k <= CORDIC_STEPS; k++)
                co_v_reg[k] <= co_v_reg[k-1];
            gn_v_reg  <= co_v_reg[CORDIC_STEPS];
            out_v_reg <= gn_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= ROOT_W; k++)
                sq_reg[k] <= sq_next[k];
            for (int k = 0; k <= Q_W; k++)
                dv_reg[k] <= dv_next[k];
            mu_reg <= mu_next;
            for (int k = 0; k <= CORDIC_STEPS; k++)
                co_reg[k] <= co_next[k];
            gn_reg     <= gn_next;
            src_x_reg  <= src_x_next;
            src_y_reg  <= src_y_next;
            inside_reg <= gn_reg.in_rad;
        end
    end

    assign out_valid  = out_v_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

[rtl/swirl_coordinate_map_core.sv]
// Top level of the swirl (twirl) coordinate map: configuration registers,
// front classifier, decoupling queue and arithmetic back end.
// Depends on swcm_pkg, swcm_front, swcm_queue and swcm_back.
`default_nettype none

// The block maps one destination pixel coordinate to the source coordinate
// of a twirl distortion about a programmable center. It accepts one
// transaction per clock when there is no back-pressure and returns one
// result transaction per input, in order. An item passes through 61
// registers: two in the front classifier, one queue slot, twenty-one
// square-root registers (a load and twenty steps), seventeen division
// registers (a load and sixteen steps), the twist product, seventeen
// CORDIC registers (the fold and sixteen rotations), the gain multiply
// and the output register. The square root, divider and CORDIC each
// resolve one bit or one rotation per stage. Points on or beyond the
// radius (all points when the radius is zero) come back as the input
// times 256 with the inside flag clear. Configuration writes take
// effect on the next cycle and should only be made while no transaction
// is in flight.
module swirl_coordinate_map_core
    import swcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // dest_x[11:0], dest_y[23:12]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // src_x[21:0], src_y[43:22], zeros
    output logic                  m_tuser,   // inside_res
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [DIM_W-1:0]       swirl_center_x_reg;
    logic [DIM_W-1:0]       swirl_center_y_reg;
    logic [DIM_W-1:0]       swirl_radius_reg;
    logic signed [TW_W-1:0] twist_amount_reg;
    logic [DIM_W-1:0]       center_x_cl;
    logic [DIM_W-1:0]       center_y_cl;

    logic       fq_valid;
    logic       fq_ready;
    swcm_item_t fq_item;
    logic       qb_valid;
    logic       qb_ready;
    swcm_item_t qb_item;
    logic [OUT_W-1:0] src_x;
    logic [OUT_W-1:0] src_y;
    logic             inside_res;

    // Register writes take effect at the clock edge that samples cfg_we; the two-bit index covers all four registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swirl_center_x_reg <= '0;
            swirl_center_y_reg <= '0;
            swirl_radius_reg   <= DIM_W'(100);
            twist_amount_reg   <= TW_W'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CENTER_X: swirl_center_x_reg <= cfg_wdata[DIM_W-1:0];
                REG_CENTER_Y: swirl_center_y_reg <= cfg_wdata[DIM_W-1:0];
                REG_RADIUS:   swirl_radius_reg   <= cfg_wdata[DIM_W-1:0];
                REG_TWIST:    twist_amount_reg   <= $signed(cfg_wdata[TW_W-1:0]);
                default:      ;
            endcase
        end
    end

    // Centers beyond the image limit saturate to its last pixel.
    assign center_x_cl = clamp_dim(swirl_center_x_reg);
    assign center_y_cl = clamp_dim(swirl_center_y_reg);

    swcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dest_x    (s_tdata[DIM_W-1:0]),
        .dest_y    (s_tdata[2*DIM_W-1:DIM_W]),
        .ctr_x     (center_x_cl),
        .ctr_y     (center_y_cl),
        .radius    (swirl_radius_reg),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    swcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    swcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_item    (qb_item),
        .radius     (swirl_radius_reg),
        .twist      (twist_amount_reg),
        .ctr_x      (center_x_cl),
        .ctr_y      (center_y_cl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .src_x      (src_x),
        .src_y      (src_y),
        .inside_res (inside_res)
    );

    assign m_tdata = {4'b0000, src_y, src_x};
    assign m_tuser = inside_res;

`ifndef SYNTHESIS
    // A point passed through unchanged has no fractional part.
    a_pass_whole: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[OUT_FRAC-1:0] == '0)
        else $error("pass-through result carries fraction bits");

    // A zero radius disables the swirl, so no result may be flagged inside.
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> swirl_radius_reg != '0)
        else $error("inside flag set with zero radius");

    // The input side only stalls when the front holds an item for the queue.
    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> fq_valid && !fq_ready)
        else $error("input stalled without a blocked front item");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the swirl coordinate map core.
// Depends on swcm_pkg and swirl_coordinate_map_core, which brings in the front, queue and back.
module tb_top;
    import swcm_pkg::*;

    // Clock and reset.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Input stream, output stream and the configuration port.
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // dest_x[11:0], dest_y[23:12]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;        // src_x[21:0], src_y[43:22], zeros
    logic                  m_tuser;        // inside_res
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // One predicted source coordinate.
    typedef struct {
        logic [OUT_W-1:0] src_x;
        logic [OUT_W-1:0] src_y;
        logic             in_rad;
    } src_coord_t;

    // Predicted coordinates still waiting for their result transaction.
    src_coord_t pending_coords[$];

    // Bench copy of the configuration registers.
    logic [11:0] cur_cx = 12'd0;
    logic [11:0] cur_cy = 12'd0;
    logic [11:0] cur_radius = 12'd100;
    logic [23:0] cur_twist = 24'd16384;

    // Idling percentages for the sender and the receiver.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned mismatches = 0;

    swirl_coordinate_map_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Integer square root, one result bit per pass.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Works out the source coordinate for one destination pixel.
    function automatic src_coord_t map_coord(input logic [11:0] px_in,
                                             input logic [11:0] py_in);
        src_coord_t res;
        longint px, py, cx, cy, rad, dx, dy, rsq, f, twist, theta, a, x, y, xs, ys;
        longint unsigned r8;
        logic [31:0] ua;
        px = px_in;
        py = py_in;
        cx = cur_cx;
        cy = cur_cy;
        rad = cur_radius;
        dx = px - cx;
        dy = py - cy;
        rsq = dx * dx + dy * dy;
        if (rsq >= rad * rad)
        begin
            res.src_x = OUT_W'(px * 256);
            res.src_y = OUT_W'(py * 256);
            res.in_rad = 1'b0;
            return res;
        end
        r8 = int_sqrt(longint'(rsq) << 16);
        f = 65536 - longint'((r8 * 256) / longint'(rad));
        twist = longint'(signed'(cur_twist));
        theta = twist * f;
        ua = 32'(-theta);
        a = longint'(signed'(ua));
        x = dx * 65536;
        y = dy * 65536;
        // Angles beyond a quarter turn are folded by a half-turn flip first.
        if (a > 64'sd1073741824)
        begin
            x = -x;
            y = -y;
            a = a - 64'sd2147483648;
        end
        else if (a < -64'sd1073741824)
        begin
            x = -x;
            y = -y;
            a = a + 64'sd2147483648;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0)
            begin
                x = x - ys;
                y = y + xs;
                a = a - longint'(ATAN_TURN32[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                a = a + longint'(ATAN_TURN32[i]);
            end
        end
        x = (x * 39797 + (64'sd1 << 23)) >>> 24;
        y = (y * 39797 + (64'sd1 << 23)) >>> 24;
        res.src_x = OUT_W'(x + cx * 256);
        res.src_y = OUT_W'(y + cy * 256);
        res.in_rad = 1'b1;
        return res;
    endfunction

    // Receiver readiness, redrawn every cycle.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Each result transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        src_coord_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_coords.size() == 0)
            begin
                $error("result with no prediction waiting: tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                exp_c = pending_coords.pop_front();
                if (m_tdata[21:0] !== exp_c.src_x)
                begin
                    $error("src_x expected %h actual %h", exp_c.src_x, m_tdata[21:0]);
                    mismatches++;
                end
                if (m_tdata[43:22] !== exp_c.src_y)
                begin
                    $error("src_y expected %h actual %h", exp_c.src_y, m_tdata[43:22]);
                    mismatches++;
                end
                if (m_tuser !== exp_c.in_rad)
                begin
                    $error("inside_res expected %b actual %b", exp_c.in_rad, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Sends one pixel, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        do
            @(posedge clk);
        while (!s_tready);
        pending_coords.push_back(map_coord(px, py));
    endtask

    // Waits until every predicted result has come back, then lets the pipe settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_coords.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CENTER_X: cur_cx = val[11:0];
            REG_CENTER_Y: cur_cy = val[11:0];
            REG_RADIUS:   cur_radius = val[11:0];
            default:      cur_twist = val;
        endcase
    endtask

    task automatic set_swirl(input logic [11:0] cx, input logic [11:0] cy,
                             input logic [11:0] rad, input logic [23:0] tw);
        write_reg(REG_CENTER_X, 24'(cx));
        write_reg(REG_CENTER_Y, 24'(cy));
        write_reg(REG_RADIUS, 24'(rad));
        write_reg(REG_TWIST, tw);
        @(posedge clk);
    endtask

    // A coordinate within the radius of a center, kept on the image.
    function automatic logic [11:0] near(input logic [11:0] c, input int rad);
        int v;
        v = int'(c) + int'($urandom_range(2 * rad)) - rad;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Reset values, the field extremes, the radius edge, the center itself, extreme twists and a zero radius.
    task automatic test_directed();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd50, 12'd30);
        send_pixel(12'd100, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain_results();
        set_swirl(12'd2048, 12'd2048, 12'd4095, 24'h7FFFFF);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'd4095, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        send_pixel(12'd2048, 12'd4095);
        send_pixel(12'd0, 12'd0);
        // Here the sender holds off until the pipe is empty.
        drain_results();
        send_pixel(12'd2100, 12'd1900);
        drain_results();
        set_swirl(12'd2048, 12'd2048, 12'd4095, 24'h800000);
        send_pixel(12'd2048, 12'd2049);
        send_pixel(12'd1000, 12'd3000);
        send_pixel(12'd4095, 12'd4095);
        drain_results();
        set_swirl(12'd4095, 12'd0, 12'd0, 24'h000000);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd1234, 12'd2345);
        drain_results();
        set_swirl(12'd10, 12'd10, 12'd5, 24'hFFC000);
        send_pixel(12'd13, 12'd14);
        send_pixel(12'd15, 12'd10);
        send_pixel(12'd12, 12'd9);
        send_pixel(12'd10, 12'd10);
        drain_results();
    endtask

    // Random settings and pixels, mostly near the center so the rotation is exercised.
    task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                               input int n_items);
        int rad;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int blk = 0; blk < 3; blk++)
        begin
            rad = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(1, 300);
            set_swirl(12'($urandom), 12'($urandom), 12'(rad), 24'($urandom));
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(9) < 8)
                    send_pixel(near(cur_cx, rad), near(cur_cy, rad));
                else
                    send_pixel(12'($urandom), 12'($urandom));
            end
            drain_results();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 0, 95);
        test_random(47, 0, 95);
        test_random(0, 47, 95);
        test_random(7, 7, 95);
        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
